@@ src/jpt_pkg.sv @@
package jpt_pkg;

   // Default longest accepted array index, in decimal digits
   localparam int MAX_DIGITS_DEFAULT = 19;

   // Result slots held for one input item; one item causes at most three results
   localparam int MAX_RESULTS = 4;
   localparam int COUNT_W = 3;

   // Path characters
   localparam logic [7:0] CH_DOLLAR    = 8'h24;
   localparam logic [7:0] CH_STAR      = 8'h2a;
   localparam logic [7:0] CH_HASH      = 8'h23;
   localparam logic [7:0] CH_MINUS     = 8'h2d;
   localparam logic [7:0] CH_DOT       = 8'h2e;
   localparam logic [7:0] CH_LBRACKET  = 8'h5b;
   localparam logic [7:0] CH_RBRACKET  = 8'h5d;
   localparam logic [7:0] CH_QUOTE     = 8'h22;
   localparam logic [7:0] CH_BACKSLASH = 8'h5c;
   localparam logic [7:0] CH_ZERO      = 8'h30;

   typedef enum logic [3:0] {
      K_KEYBYTE  = 4'd0,
      K_KEYEND   = 4'd1,
      K_WILD     = 4'd2,
      K_RECWILD  = 4'd3,
      K_INDEX    = 4'd4,
      K_REVINDEX = 4'd5,
      K_APPEND   = 4'd6,
      K_ERROR    = 4'd7,
      K_PATHEND  = 4'd8
   } kind_type;

   typedef enum logic [3:0] {
      P_START,
      P_BETWEEN,
      P_DOT1,
      P_STAR1,
      P_DOT2,
      P_UKEY,
      P_QKEY,
      P_QESC,
      P_BRACKET,
      P_BSTAR,
      P_BHASH,
      P_BDIGITS,
      P_ERR
   } phase_type;

   typedef struct packed {
      phase_type   phase;
      logic [63:0] index_accum;
      logic        index_reverse;
      logic        key_recursive;
      logic        key_nonempty;
      logic        saw_wildcard;
   } state_type;

   localparam state_type STATE_RESET = '{
      phase         : P_START,
      index_accum   : 64'd0,
      index_reverse : 1'b0,
      key_recursive : 1'b0,
      key_nonempty  : 1'b0,
      saw_wildcard  : 1'b0
   };

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  key_byte;
      logic [63:0] index_value;
      logic        recursive_key;
      logic        wildcard_path;
   } result_type;

   typedef result_type [MAX_RESULTS-1:0] result_list_type;

   // Build one result, zeroing the fields that do not belong to its kind
   function automatic result_type make_result(kind_type k, logic [7:0] b,
                                              logic [63:0] idx, logic rec,
                                              logic wild);
      result_type r;
      r.kind          = k;
      r.key_byte      = (k == K_KEYBYTE) ? b : 8'd0;
      r.index_value   = (k == K_INDEX || k == K_REVINDEX) ? idx : 64'd0;
      r.recursive_key = (k == K_KEYBYTE || k == K_KEYEND) ? rec : 1'b0;
      r.wildcard_path = (k == K_PATHEND) ? wild : 1'b0;
      return r;
   endfunction

endpackage

@@ src/json_path_tokenizer.sv @@
// The results of an item appear in the cycle after it is accepted.
// Throughput: one byte per cycle when it causes at most one result and rsp_ready
// stays high; a byte causing more results holds the buffer until all have drained.
// Results drain from a four-entry burst register, one per cycle while rsp_ready is high.
// Reset is synchronous, active high; it clears the lexer state and the buffer.
module json_path_tokenizer #(
   parameter int MAX_DIGITS = jpt_pkg::MAX_DIGITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_ch,
   input  logic        req_final_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_kind,
   output logic [7:0]  rsp_key_byte,
   output logic [63:0] rsp_index_value,
   output logic        rsp_recursive_key,
   output logic        rsp_wildcard_path,
   output logic        rsp_run_last
);

   localparam int DIGIT_W = $clog2(MAX_DIGITS + 1);

   jpt_pkg::state_type          state_ff;
   jpt_pkg::state_type          state_in;
   logic [DIGIT_W-1:0]          digits_ff;
   logic [DIGIT_W-1:0]          digits_in;
   jpt_pkg::result_list_type    step_res;
   logic [jpt_pkg::COUNT_W-1:0] step_cnt;
   logic                        accept;
   jpt_pkg::result_type         out_res;

   assign accept = req_valid && req_ready;

   jpt_step #(
      .MAX_DIGITS (MAX_DIGITS),
      .DIGIT_W    (DIGIT_W)
   ) u_step (
      .cur        (state_ff),
      .digits     (digits_ff),
      .ch         (req_ch),
      .final_byte (req_final_byte),
      .nxt        (state_in),
      .digits_nxt (digits_in),
      .res        (step_res),
      .res_cnt    (step_cnt)
   );

   jpt_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .load      (accept),
      .load_res  (step_res),
      .load_cnt  (step_cnt),
      .free      (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_res   (out_res),
      .rsp_last  (rsp_run_last)
   );

   // Advance the lexer state on each accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= jpt_pkg::STATE_RESET;
         digits_ff <= '0;
      end else if (accept) begin
         state_ff  <= state_in;
         digits_ff <= digits_in;
      end
   end

   assign rsp_kind          = out_res.kind;
   assign rsp_key_byte      = out_res.key_byte;
   assign rsp_index_value   = out_res.index_value;
   assign rsp_recursive_key = out_res.recursive_key;
   assign rsp_wildcard_path = out_res.wildcard_path;

endmodule

@@ src/jpt_step.sv @@
module jpt_step #(
   parameter int MAX_DIGITS = jpt_pkg::MAX_DIGITS_DEFAULT,
   parameter int DIGIT_W = $clog2(MAX_DIGITS + 1)
) (
   input  jpt_pkg::state_type                 cur,
   input  logic [DIGIT_W-1:0]                 digits,
   input  logic [7:0]                         ch,
   input  logic                               final_byte,
   output jpt_pkg::state_type                 nxt,
   output logic [DIGIT_W-1:0]                 digits_nxt,
   output jpt_pkg::result_list_type           res,
   output logic [jpt_pkg::COUNT_W-1:0]        res_cnt
);

   logic [jpt_pkg::COUNT_W-1:0] cnt;
   logic                        do_sep;
   logic [7:0]                  sep_ch;
   logic                        do_digit;
   logic [7:0]                  dval;

   assign dval = ch - jpt_pkg::CH_ZERO;

   // Decode one byte: advance the phase and collect the results it causes
   always_comb begin
      nxt        = cur;
      digits_nxt = digits;
      res        = '0;
      cnt        = '0;
      do_sep     = 1'b0;
      sep_ch     = ch;
      do_digit   = 1'b0;

      unique case (cur.phase)
         jpt_pkg::P_START: begin
            if (ch == jpt_pkg::CH_DOLLAR) begin
               nxt.phase = jpt_pkg::P_BETWEEN;
            end else begin
               res[cnt[1:0]] = jpt_pkg::make_result(jpt_pkg::K_ERROR, 8'd0, 64'd0,
                                                    1'b0, 1'b0);
               cnt = cnt + 3'd1;
               nxt.phase = jpt_pkg::P_ERR;
            end
         end
         jpt_pkg::P_BETWEEN: begin
            do_sep = 1'b1;
         end
         jpt_pkg::P_DOT1: begin
            nxt.key_recursive = 1'b0;
            nxt.key_nonempty  = 1'b0;
            if (ch == jpt_pkg::CH_STAR) begin
               nxt.phase = jpt_pkg::P_STAR1;
            end else if (ch == jpt_pkg::CH_DOT) begin
               nxt.phase = jpt_pkg::P_DOT2;
            end else if (ch == jpt_pkg::CH_QUOTE) begin
               nxt.phase = jpt_pkg::P_QKEY;
            end else if (ch == jpt_pkg::CH_LBRACKET) begin
               res[cnt[1:0]] = jpt_pkg::make_result(jpt_pkg::K_ERROR, 8'd0, 64'd0,
                                                    1'b0, 1'b0);
               cnt = cnt + 3'd1;
               nxt.phase = jpt_pkg::P_ERR;
            end else begin
               res[cnt[1:0]] = jpt_pkg::make_result(jpt_pkg::K_KEYBYTE, ch, 64'd0,
                                                    nxt.key_recursive, 1'b0);
               cnt = cnt + 3'd1;
               nxt.key_nonempty = 1'b1;
               nxt.phase = jpt_pkg::P_UKEY;
            end
         end
         jpt_pkg::P_STAR1: begin
            nxt.saw_wildcard = 1'b1;
            if (ch == jpt_pkg::CH_STAR) begin
               res[cnt[1:0]] = jpt_pkg::make_result(jpt_pkg::K_RECWILD, 8'd0, 64'd0,
                                                    1'b0, 1'b0);
               cnt = cnt + 3'd1;
               nxt.phase = jpt_pkg::P_BETWEEN;
            end else begin
               res[cnt[1:0]] = jpt_pkg::make_result(jpt_pkg::K_WILD, 8'd0, 64'd0,
                                                    1'b0, 1'b0);
               cnt = cnt + 3'd1;
               do_sep = 1'b1;
            end
         end
         jpt_pkg::P_DOT2: begin
            if (ch == jpt_pkg::CH_STAR || ch == jpt_pkg::CH_LBRACKET) begin
               nxt.saw_wildcard = 1'b1;
               res[cnt[1:0]] = jpt_pkg::make_result(jpt_pkg::K_RECWILD, 8'd0, 64'd0,
                                                    1'b0, 1'b0);
               cnt = cnt + 3'd1;
               nxt.phase = (ch == jpt_pkg::CH_STAR) ? jpt_pkg::P_BETWEEN
                                                    : jpt_pkg::P_BRACKET;
            end else if (ch == jpt_pkg::CH_DOT) begin
               res[cnt[1:0]] = jpt_pkg::make_result(jpt_pkg::K_ERROR, 8'd0, 64'd0,
                                                    1'b0, 1'b0);
               cnt = cnt + 3'd1;
               nxt.phase = jpt_pkg::P_ERR;
            end else begin
               nxt.saw_wildcard  = 1'b1;
               nxt.key_recursive = 1'b1;
               nxt.key_nonempty  = 1'b0;
               if (ch == jpt_pkg::CH_QUOTE) begin
                  nxt.phase = jpt_pkg::P_QKEY;
               end else begin
                  res[cnt[1:0]] = jpt_pkg::make_result(jpt_pkg::K_KEYBYTE, ch, 64'd0,
                                                       nxt.key_recursive, 1'b0);
                  cnt = cnt + 3'd1;
                  nxt.key_nonempty = 1'b1;
                  nxt.phase = jpt_pkg::P_UKEY;
               end
            end
         end
         jpt_pkg::P_UKEY: begin
            if (ch == jpt_pkg::CH_DOT || ch == jpt_pkg::CH_LBRACKET) begin
               res[cnt[1:0]] = jpt_pkg::make_result(jpt_pkg::K_KEYEND, 8'd0, 64'd0,
                                                    nxt.key_recursive, 1'b0);
               cnt = cnt + 3'd1;
               do_sep = 1'b1;
            end else begin
               res[cnt[1:0]] = jpt_pkg::make_result(jpt_pkg::K_KEYBYTE, ch, 64'd0,
                                                    nxt.key_recursive, 1'b0);
               cnt = cnt + 3'd1;
               nxt.key_nonempty = 1'b1;
            end
         end
         jpt_pkg::P_QKEY: begin
            if (ch == jpt_pkg::CH_QUOTE) begin
               if (cur.key_nonempty) begin
                  res[cnt[1:0]] = jpt_pkg::make_result(jpt_pkg::K_KEYEND, 8'd0, 64'd0,
                                                       nxt.key_recursive, 1'b0);
                  cnt = cnt + 3'd1;
                  nxt.phase = jpt_pkg::P_BETWEEN;
               end else begin
                  res[cnt[1:0]] = jpt_pkg::make_result(jpt_pkg::K_ERROR, 8'd0, 64'd0,
                                                       1'b0, 1'b0);
                  cnt = cnt + 3'd1;
                  nxt.phase = jpt_pkg::P_ERR;
               end
            end else if (ch == jpt_pkg::CH_BACKSLASH) begin
               nxt.phase = jpt_pkg::P_QESC;
            end else begin
               res[cnt[1:0]] = jpt_pkg::make_result(jpt_pkg::K_KEYBYTE, ch, 64'd0,
                                                    nxt.key_recursive, 1'b0);
               cnt = cnt + 3'd1;
               nxt.key_nonempty = 1'b1;
            end
         end
         jpt_pkg::P_QESC: begin
            // Keep the backslash unless it escapes a quote or a backslash
            if (ch != jpt_pkg::CH_QUOTE && ch != jpt_pkg::CH_BACKSLASH) begin
               res[cnt[1:0]] = jpt_pkg::make_result(jpt_pkg::K_KEYBYTE,
                                                    jpt_pkg::CH_BACKSLASH, 64'd0,
                                                    nxt.key_recursive, 1'b0);
               cnt = cnt + 3'd1;
            end
            res[cnt[1:0]] = jpt_pkg::make_result(jpt_pkg::K_KEYBYTE, ch, 64'd0,
                                                 nxt.key_recursive, 1'b0);
            cnt = cnt + 3'd1;
            nxt.key_nonempty = 1'b1;
            nxt.phase = jpt_pkg::P_QKEY;
         end
         jpt_pkg::P_BRACKET: begin
            nxt.index_accum   = 64'd0;
            nxt.index_reverse = 1'b0;
            digits_nxt        = '0;
            if (ch == jpt_pkg::CH_STAR) begin
               nxt.phase = jpt_pkg::P_BSTAR;
            end else if (ch == jpt_pkg::CH_HASH) begin
               nxt.phase = jpt_pkg::P_BHASH;
            end else if (ch == jpt_pkg::CH_MINUS) begin
               nxt.index_reverse = 1'b1;
               nxt.phase = jpt_pkg::P_BDIGITS;
            end else begin
               nxt.phase = jpt_pkg::P_BDIGITS;
               do_digit = 1'b1;
            end
         end
         jpt_pkg::P_BSTAR: begin
            if (ch == jpt_pkg::CH_RBRACKET) begin
               nxt.saw_wildcard = 1'b1;
               res[cnt[1:0]] = jpt_pkg::make_result(jpt_pkg::K_WILD, 8'd0, 64'd0,
                                                    1'b0, 1'b0);
               cnt = cnt + 3'd1;
               nxt.phase = jpt_pkg::P_BETWEEN;
            end else begin
               res[cnt[1:0]] = jpt_pkg::make_result(jpt_pkg::K_ERROR, 8'd0, 64'd0,
                                                    1'b0, 1'b0);
               cnt = cnt + 3'd1;
               nxt.phase = jpt_pkg::P_ERR;
            end
         end
         jpt_pkg::P_BHASH: begin
            if (ch == jpt_pkg::CH_RBRACKET) begin
               res[cnt[1:0]] = jpt_pkg::make_result(jpt_pkg::K_APPEND, 8'd0, 64'd0,
                                                    1'b0, 1'b0);
               cnt = cnt + 3'd1;
               nxt.phase = jpt_pkg::P_BETWEEN;
            end else if (ch == jpt_pkg::CH_MINUS) begin
               nxt.index_reverse = 1'b1;
               nxt.phase = jpt_pkg::P_BDIGITS;
            end else begin
               res[cnt[1:0]] = jpt_pkg::make_result(jpt_pkg::K_ERROR, 8'd0, 64'd0,
                                                    1'b0, 1'b0);
               cnt = cnt + 3'd1;
               nxt.phase = jpt_pkg::P_ERR;
            end
         end
         jpt_pkg::P_BDIGITS: begin
            do_digit = 1'b1;
         end
         jpt_pkg::P_ERR: begin
            nxt.phase = jpt_pkg::P_ERR;
         end
         default: begin
            nxt.phase = jpt_pkg::P_ERR;
         end
      endcase

      // Step separator: '.' opens a key step, '[' an array step
      if (do_sep) begin
         if (sep_ch == jpt_pkg::CH_DOT) begin
            nxt.phase = jpt_pkg::P_DOT1;
         end else if (sep_ch == jpt_pkg::CH_LBRACKET) begin
            nxt.phase = jpt_pkg::P_BRACKET;
         end else begin
            res[cnt[1:0]] = jpt_pkg::make_result(jpt_pkg::K_ERROR, 8'd0, 64'd0,
                                                 1'b0, 1'b0);
            cnt = cnt + 3'd1;
            nxt.phase = jpt_pkg::P_ERR;
         end
      end

      // Index digits: close on ']' after at least one digit, accumulate a decimal digit up to MAX_DIGITS, else fail
      if (do_digit) begin
         if (ch == jpt_pkg::CH_RBRACKET) begin
            if (digits_nxt == '0) begin
               res[cnt[1:0]] = jpt_pkg::make_result(jpt_pkg::K_ERROR, 8'd0, 64'd0,
                                                    1'b0, 1'b0);
               cnt = cnt + 3'd1;
               nxt.phase = jpt_pkg::P_ERR;
            end else begin
               res[cnt[1:0]] = jpt_pkg::make_result(
                  nxt.index_reverse ? jpt_pkg::K_REVINDEX : jpt_pkg::K_INDEX,
                  8'd0, nxt.index_accum, 1'b0, 1'b0);
               cnt = cnt + 3'd1;
               nxt.phase = jpt_pkg::P_BETWEEN;
            end
         end else if (dval <= 8'd9 && digits_nxt < DIGIT_W'(MAX_DIGITS)) begin
            nxt.index_accum = {nxt.index_accum[60:0], 3'b000}
                            + {nxt.index_accum[62:0], 1'b0}
                            + {56'd0, dval};
            digits_nxt = digits_nxt + DIGIT_W'(1);
         end else begin
            res[cnt[1:0]] = jpt_pkg::make_result(jpt_pkg::K_ERROR, 8'd0, 64'd0,
                                                 1'b0, 1'b0);
            cnt = cnt + 3'd1;
            nxt.phase = jpt_pkg::P_ERR;
         end
      end

      // Path end: close what is open, report, and return to the reset state
      if (final_byte) begin
         unique case (nxt.phase)
            jpt_pkg::P_ERR: begin
            end
            jpt_pkg::P_BETWEEN: begin
               res[cnt[1:0]] = jpt_pkg::make_result(jpt_pkg::K_PATHEND, 8'd0, 64'd0,
                                                    1'b0, nxt.saw_wildcard);
               cnt = cnt + 3'd1;
            end
            jpt_pkg::P_UKEY: begin
               res[cnt[1:0]] = jpt_pkg::make_result(jpt_pkg::K_KEYEND, 8'd0, 64'd0,
                                                    nxt.key_recursive, 1'b0);
               cnt = cnt + 3'd1;
               res[cnt[1:0]] = jpt_pkg::make_result(jpt_pkg::K_PATHEND, 8'd0, 64'd0,
                                                    1'b0, nxt.saw_wildcard);
               cnt = cnt + 3'd1;
            end
            jpt_pkg::P_STAR1: begin
               nxt.saw_wildcard = 1'b1;
               res[cnt[1:0]] = jpt_pkg::make_result(jpt_pkg::K_WILD, 8'd0, 64'd0,
                                                    1'b0, 1'b0);
               cnt = cnt + 3'd1;
               res[cnt[1:0]] = jpt_pkg::make_result(jpt_pkg::K_PATHEND, 8'd0, 64'd0,
                                                    1'b0, nxt.saw_wildcard);
               cnt = cnt + 3'd1;
            end
            default: begin
               res[cnt[1:0]] = jpt_pkg::make_result(jpt_pkg::K_ERROR, 8'd0, 64'd0,
                                                    1'b0, 1'b0);
               cnt = cnt + 3'd1;
            end
         endcase
         nxt        = jpt_pkg::STATE_RESET;
         digits_nxt = '0;
      end

      res_cnt = cnt;
   end

endmodule

@@ src/jpt_rsp_queue.sv @@
module jpt_rsp_queue (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               load,
   input  jpt_pkg::result_list_type           load_res,
   input  logic [jpt_pkg::COUNT_W-1:0]        load_cnt,
   output logic                               free,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output jpt_pkg::result_type                rsp_res,
   output logic                               rsp_last
);

   jpt_pkg::result_list_type    slots_ff;
   logic [jpt_pkg::COUNT_W-1:0] cnt_ff;
   logic [jpt_pkg::COUNT_W-1:0] ptr_ff;
   logic [jpt_pkg::COUNT_W-1:0] ptr_in;
   logic [jpt_pkg::COUNT_W-1:0] ptr_next;

   assign ptr_next  = ptr_ff + 3'd1;
   assign rsp_valid = (ptr_ff != cnt_ff);
   assign rsp_last  = (ptr_next == cnt_ff);
   assign rsp_res   = slots_ff[ptr_ff[1:0]];

   // Free once empty, or when the last pending result leaves this cycle
   assign free = !rsp_valid || (rsp_last && rsp_ready);

   always_comb begin
      ptr_in = ptr_ff;
      if (load) begin
         ptr_in = '0;
      end else if (rsp_valid && rsp_ready) begin
         ptr_in = ptr_next;
      end
   end

   // Hold the burst of one item and step through it
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         ptr_ff <= '0;
      end else begin
         ptr_ff <= ptr_in;
         if (load) begin
            cnt_ff <= load_cnt;
         end
      end
      if (load) begin
         slots_ff <= load_res;
      end
   end

endmodule

@@ src/jpt_checker.sv @@
module jpt_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [3:0]  rsp_kind,
   input logic [7:0]  rsp_key_byte,
   input logic [63:0] rsp_index_value,
   input logic        rsp_run_last
);

   // A stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind)
         && $stable(rsp_key_byte) && $stable(rsp_index_value))
      else $error("stalled result changed");

   // No new item while more results of the current one are pending
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_run_last |-> !req_ready)
      else $error("item taken with results still pending");

   // Path end is always the last result of its item
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == jpt_pkg::K_PATHEND |-> rsp_run_last)
      else $error("path end not last in burst");

   // Key byte and index are zero on results that are neither key bytes nor indices
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != jpt_pkg::K_KEYBYTE && rsp_kind != jpt_pkg::K_INDEX
         && rsp_kind != jpt_pkg::K_REVINDEX |-> rsp_key_byte == 8'd0
         && rsp_index_value == 64'd0)
      else $error("stray payload on result");

endmodule

bind json_path_tokenizer jpt_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_kind        (rsp_kind),
   .rsp_key_byte    (rsp_key_byte),
   .rsp_index_value (rsp_index_value),
   .rsp_run_last    (rsp_run_last)
);
